// ===== rtl/core/skf3_pkg.sv =====
// Shared constants and types for the three-axis scalar Kalman filter.
package skf3_pkg;

    // default widths of the sample and of the fraction of the Q format
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // gain format: unsigned Q1.16; the integer bit lets one itself fit
    localparam int GAIN_FRAC = 16;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

    // data path widths
    localparam int VAL_W = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_VAR = 2'd1;
    localparam logic [VAL_W-1:0] MEAS_VAR_RST = 32'd2287010;
    localparam logic [VAL_W-1:0] PROC_VAR_RST = 32'd61573;

    // control from the sequencer to each axis lane
    typedef struct packed {
        logic              go;
        logic [GAIN_W-1:0] gain;
    } t_lane_ctl;

endpackage

// ===== rtl/core/skf3_if.sv =====
// Handshake interfaces for the sample and estimate channels.
interface skf3_smp_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] raw_x;
    logic signed [SAMPLE_BITS-1:0] raw_y;
    logic signed [SAMPLE_BITS-1:0] raw_z;

    modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface skf3_est_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_z;
    logic [16:0]        gain;

    modport source (output valid, output est_x, output est_y, output est_z, output gain,
                    input ready);
    modport sink   (input valid, input est_x, input est_y, input est_z, input gain,
                    output ready);
endinterface

// ===== rtl/core/scalar_kalman_3axis.sv =====
// Three-axis scalar Kalman filter: sequencer, shared gain divider, axis lanes, merge stage.
// A sample passes the prior, divider and lane states before its estimate is offered.
// Samples are handled one at a time; the 17-step serial divider dominates each one.
// A new sample is taken as soon as the merged result is parked in the output register.
// Reset (synchronous, active low) clears covariance, estimates and the sequencer, and
// loads the variance registers with their defaults; no clearing pass is needed.
module scalar_kalman_3axis
    import skf3_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    skf3_smp_if.sink             i_smp,
    skf3_est_if.source           o_est,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIOR = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_LANE  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam int NLANE  = 3;
    localparam int CPRD_W = VAL_W + GAIN_W;

    logic [2:0] r_state;

    // configuration and filter state
    logic [VAL_W-1:0] r_meas;
    logic [VAL_W-1:0] r_proc;
    logic [VAL_W-1:0] r_cov;

    // per-item working registers
    logic signed [SAMPLE_BITS-1:0] r_raw [NLANE];
    logic [VAL_W-1:0]  r_prior;
    logic              r_den_zero;
    logic [GAIN_W-1:0] r_gain;

    // output register (merge stage)
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_est [NLANE];
    logic [GAIN_W-1:0]       r_out_gain;

    logic [VAL_W:0]          w_prior_sum;
    logic [VAL_W-1:0]        w_prior;
    logic [VAL_W:0]          w_den;
    logic                    w_div_done;
    logic [GAIN_W-1:0]       w_div_quo;
    logic [GAIN_W-1:0]       w_gain;
    logic [CPRD_W-1:0]       w_cov_prod;
    t_lane_ctl               w_lane_ctl;
    logic [NLANE-1:0]        w_lane_done;
    logic signed [VAL_W-1:0] w_lane_est [NLANE];
    logic                    w_accept;
    logic                    w_out_load;

    assign w_accept   = i_smp.valid && i_smp.ready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_est.ready);

    // prior covariance, saturated; denominator kept at full width
    assign w_prior_sum = {1'b0, r_cov} + {1'b0, r_proc};
    assign w_prior     = w_prior_sum[VAL_W] ? '1 : w_prior_sum[VAL_W-1:0];
    assign w_den       = {1'b0, w_prior} + {1'b0, r_meas};

    // zero denominator: gain forced to zero, so nothing moves
    assign w_gain = r_den_zero ? '0 : w_div_quo;

    assign w_lane_ctl.go   = (r_state == S_DIV) && w_div_done;
    assign w_lane_ctl.gain = w_gain;

    // new covariance = prior * (1 - gain)
    assign w_cov_prod = CPRD_W'(r_prior) * CPRD_W'(GAIN_ONE - r_gain);

    skf3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PRIOR),
        .i_num   (w_prior),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        skf3_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .FRAC_BITS   (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_lane_ctl),
            .i_raw   (r_raw[l]),
            .o_done  (w_lane_done[l]),
            .o_est   (w_lane_est[l])
        );
    end

    // configuration writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas <= MEAS_VAR_RST;
            r_proc <= PROC_VAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEAS_VAR: r_meas <= i_cfg_data;
                CFG_PROC_VAR: r_proc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cov       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new load wins over the departing transaction
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_est.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_PRIOR;
                    end
                end
                S_PRIOR: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_LANE;
                    end
                end
                S_LANE: begin
                    if (w_lane_done[0]) begin
                        r_cov   <= w_cov_prod[GAIN_FRAC+VAL_W-1:GAIN_FRAC];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw[0] <= i_smp.raw_x;
            r_raw[1] <= i_smp.raw_y;
            r_raw[2] <= i_smp.raw_z;
        end
        if (r_state == S_PRIOR) begin
            r_prior    <= w_prior;
            r_den_zero <= (w_den == '0);
        end
        if (w_lane_ctl.go) begin
            r_gain <= w_gain;
        end
        if (w_out_load) begin
            for (int l = 0; l < NLANE; l++) begin
                r_out_est[l] <= w_lane_est[l];
            end
            r_out_gain <= r_gain;
        end
    end

    assign i_smp.ready = (r_state == S_IDLE);
    assign o_est.valid = r_out_valid;
    assign o_est.est_x = r_out_est[0];
    assign o_est.est_y = r_out_est[1];
    assign o_est.est_z = r_out_est[2];
    assign o_est.gain  = r_out_gain;

`ifndef SYNTHESIS
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_gain <= GAIN_ONE))
        else $error("gain beyond one");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its state");

    a_lanes_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_done[0] |-> (&w_lane_done && r_state == S_LANE))
        else $error("lanes out of step");

    a_zero_den_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LANE && r_den_zero) |-> (r_gain == '0))
        else $error("non-zero gain with zero denominator");
`endif

endmodule

// ===== rtl/core/skf3_div.sv =====
// Restoring divider, one gain bit per cycle: floor(num * 2^16 / den).
module skf3_div
    import skf3_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [VAL_W-1:0]    i_num,
    input  logic [VAL_W:0]      i_den,
    output logic                o_done,
    output logic [GAIN_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(GAIN_W + 1);
    localparam int REM_W = VAL_W + 2;

    logic [REM_W-1:0] r_rem;
    logic [VAL_W:0]   r_den;
    logic [GAIN_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic             w_ge;
    logic [REM_W-1:0] w_sub;

    // num <= den, so the first step needs no shift
    assign w_ge  = r_rem >= {1'b0, r_den};
    assign w_sub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(GAIN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {w_sub[REM_W-2:0], 1'b0};
            r_quo <= {r_quo[GAIN_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/skf3_lane.sv =====
// One axis lane: holds the estimate and moves it toward the sample by the gain.
module skf3_lane
    import skf3_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_raw,
    output logic                          o_done,
    output logic signed [VAL_W-1:0]       o_est
);

    localparam int WIDE_W = 64;
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [WIDE_W-1:0] SMAX = WIDE_W'(64'sh7FFF_FFFF);
    localparam logic signed [WIDE_W-1:0] SMIN = -WIDE_W'(64'sh8000_0000);
    localparam logic signed [SUM_W-1:0]  EMAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0]  EMIN = -SUM_W'(64'sh8000_0000);
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (GAIN_FRAC - 1);

    logic signed [VAL_W-1:0]  r_est;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p1;
    logic                     r_done;

    logic signed [WIDE_W-1:0] w_wide;
    logic signed [VAL_W-1:0]  w_smp;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_step;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [VAL_W-1:0]  w_new;

    // scaled sample, saturated to 32 bits
    assign w_wide = WIDE_W'(i_raw) <<< FRAC_BITS;
    assign w_smp  = (w_wide > SMAX) ? VAL_W'(SMAX) :
                    (w_wide < SMIN) ? VAL_W'(SMIN) : VAL_W'(w_wide);
    assign w_diff = DIFF_W'(w_smp) - DIFF_W'(r_est);

    // arithmetic shift gives the floor; the half was added before
    assign w_step = r_prod >>> GAIN_FRAC;
    assign w_sum  = SUM_W'(r_est) + SUM_W'(w_step);
    assign w_new  = (w_sum > EMAX) ? VAL_W'(EMAX) :
                    (w_sum < EMIN) ? VAL_W'(EMIN) : VAL_W'(w_sum);

    always_ff @(posedge i_clk) begin
        if (i_ctl.go) begin
            r_prod <= PROD_W'($signed({1'b0, i_ctl.gain})) * PROD_W'(w_diff) + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est  <= '0;
            r_p1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_p1   <= i_ctl.go;
            r_done <= r_p1;
            if (r_p1) begin
                r_est <= w_new;
            end
        end
    end

    assign o_done = r_done;
    assign o_est  = r_est;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the three-axis scalar Kalman filter block.
`timescale 1ns / 100ps

module testbench;
    import skf3_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RST_CYCLES      = 7;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 111;
    localparam int MAX_GAP         = 24;
    localparam int HOLD_CYCLES     = 250;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_REPORTS     = 10;
    localparam int SEND_IDLE_PCT   = 62;
    localparam int RECV_STALL_PCT  = 62;
    localparam int BOTH_IDLE_PCT   = 14;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // Register indexes the block does not decode: writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Idling schedule of a phase.
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // One accelerometer sample transaction.
    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] x;
        logic signed [SAMPLE_BITS_DEF-1:0] y;
        logic signed [SAMPLE_BITS_DEF-1:0] z;
    } accel_t;

    // One estimate transaction.
    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
        logic [GAIN_W-1:0]       gain;
    } filt_out_t;

    // Row of the directed table: optional variance set-up, then one sample.
    // Where "known" is set the expected estimate is typed in by hand.
    typedef struct packed {
        bit               set_vars;
        logic [VAL_W-1:0] meas;
        logic [VAL_W-1:0] proc;
        accel_t           smp;
        bit               known;
        filt_out_t        res;
    } dir_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [VAL_W-1:0]     cfg_data;

    skf3_smp_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) smp_ch ();
    skf3_est_if                                  est_ch ();

    scalar_kalman_3axis #(
        .SAMPLE_BITS (SAMPLE_BITS_DEF),
        .FRAC_BITS   (FRAC_BITS_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_ch),
        .o_est      (est_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Filter state as the testbench believes it to be, and the estimates
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------
    logic [VAL_W-1:0]        flt_meas_var;
    logic [VAL_W-1:0]        flt_proc_var;
    logic [VAL_W-1:0]        flt_cov;
    logic signed [VAL_W-1:0] flt_est_x;
    logic signed [VAL_W-1:0] flt_est_y;
    logic signed [VAL_W-1:0] flt_est_z;
    filt_out_t               est_expected[$];
    dir_row_t                dir_rows[$];

    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic longint clamp_s32(input longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // One axis: move the estimate towards the scaled sample by the gain,
    // rounding half up, with floor division of negative products.
    function automatic logic signed [VAL_W-1:0] axis_move(
        input logic signed [VAL_W-1:0]           est,
        input logic signed [SAMPLE_BITS_DEF-1:0] raw,
        input logic [GAIN_W-1:0]                 g
    );
        longint scaled;
        longint prod;
        longint nxt;
        scaled = clamp_s32(longint'(raw) <<< FRAC_BITS_DEF);
        prod   = longint'({1'b0, g}) * (scaled - longint'(est)) + longint'(GAIN_ONE >> 1);
        nxt    = clamp_s32(longint'(est) + (prod >>> GAIN_FRAC));
        return nxt[VAL_W-1:0];
    endfunction

    // Full filter step: prior, gain, three axis updates, posterior covariance.
    task automatic kalman_step(input accel_t s, output filt_out_t r);
        logic [VAL_W:0]    sum;
        logic [VAL_W-1:0]  prior;
        logic [63:0]       den;
        logic [63:0]       quo;
        logic [63:0]       prod;
        logic [GAIN_W-1:0] g;
        sum   = {1'b0, flt_cov} + {1'b0, flt_proc_var};
        prior = sum[VAL_W] ? '1 : sum[VAL_W-1:0];   // prior saturates
        den   = {32'd0, prior} + {32'd0, flt_meas_var};
        g     = '0;
        if (den != 64'd0) begin
            quo = ({32'd0, prior} << GAIN_FRAC) / den;
            g   = (quo > {47'd0, GAIN_ONE}) ? GAIN_ONE : quo[GAIN_W-1:0];
        end
        flt_est_x = axis_move(flt_est_x, s.x, g);
        flt_est_y = axis_move(flt_est_y, s.y, g);
        flt_est_z = axis_move(flt_est_z, s.z, g);
        prod      = {32'd0, prior} * {47'd0, GAIN_ONE - g};
        flt_cov   = prod[GAIN_FRAC +: VAL_W];
        r.x    = flt_est_x;
        r.y    = flt_est_y;
        r.z    = flt_est_z;
        r.gain = g;
    endtask

    // Register write, only with the block idle: drop valid, wait for every
    // owed estimate, then one cycle of write enable.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(negedge i_clk);
        smp_ch.valid = 1'b0;
        while (est_expected.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MEAS_VAR: flt_meas_var = data;
            CFG_PROC_VAR: flt_proc_var = data;
            default: ;
        endcase
    endtask

    // Offer one sample after an optional gap; returns at the accepting edge,
    // leaving valid high so that back-to-back transactions need no toggle.
    task automatic send_sample(input accel_t s, input bit known, input filt_out_t typed);
        filt_out_t r;
        int        gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge i_clk);
        repeat (gap) begin
            smp_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        smp_ch.valid = 1'b1;
        smp_ch.raw_x = s.x;
        smp_ch.raw_y = s.y;
        smp_ch.raw_z = s.z;
        do
            @(posedge i_clk);
        while (smp_ch.ready !== 1'b1);
        kalman_step(s, r);
        est_expected.push_back(known ? typed : r);
    endtask

    task automatic add_row(
        input bit               set_vars,
        input logic [VAL_W-1:0] meas,
        input logic [VAL_W-1:0] proc,
        input int               x,
        input int               y,
        input int               z,
        input bit               known,
        input longint           ex,
        input longint           ey,
        input longint           ez,
        input int               eg
    );
        dir_row_t row;
        row.set_vars = set_vars;
        row.meas     = meas;
        row.proc     = proc;
        row.smp.x    = x[SAMPLE_BITS_DEF-1:0];
        row.smp.y    = y[SAMPLE_BITS_DEF-1:0];
        row.smp.z    = z[SAMPLE_BITS_DEF-1:0];
        row.known    = known;
        row.res.x    = ex[VAL_W-1:0];
        row.res.y    = ey[VAL_W-1:0];
        row.res.z    = ez[VAL_W-1:0];
        row.res.gain = eg[GAIN_W-1:0];
        dir_rows.push_back(row);
    endtask

    // Sample for one axis: mostly a noisy reading around a steady value,
    // otherwise full-range noise, a rail, zero or minus one.
    function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_axis(input int centre);
        int sel;
        int v;
        sel = $urandom_range(9);
        if (sel == 0) begin
            sel = $urandom_range(3);
            v = (sel == 0) ? -32768 : (sel == 1) ? 32767 : (sel == 2) ? 0 : -1;
        end else if (sel <= 3)
            v = int'($urandom_range(65535)) - 32768;
        else
            v = centre + int'($urandom_range(400)) - 200;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_BITS_DEF-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] pick_var();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return MEAS_VAR_RST;
            3:       return PROC_VAR_RST;
            4:       return $urandom_range(1023);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Estimate sink: ready set at the falling edge (random stalls or a
    // long hold-off on request), transactions checked at the rising edge.
    // ------------------------------------------------------------------
    initial begin
        filt_out_t want;
        int        hold_left;
        hold_left    = 0;
        est_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                est_ch.ready = 1'b0;
            end else begin
                est_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge i_clk);
            if (est_ch.valid === 1'b1 && est_ch.ready === 1'b1) begin
                if (est_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected estimate: x %0d y %0d z %0d gain %0d",
                                 est_ch.est_x, est_ch.est_y, est_ch.est_z, est_ch.gain);
                end else begin
                    want = est_expected.pop_front();
                    if (est_ch.est_x !== want.x || est_ch.est_y !== want.y ||
                        est_ch.est_z !== want.z || est_ch.gain !== want.gain) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch (exp/act): x %0d/%0d y %0d/%0d z %0d/%0d gain %0d/%0d",
                                     want.x, est_ch.est_x, want.y, est_ch.est_y,
                                     want.z, est_ch.est_z, want.gain, est_ch.gain);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((smp_ch.valid === 1'b1 && smp_ch.ready === 1'b1) ||
                (est_ch.valid === 1'b1 && est_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        filt_out_t  none;
        accel_t     s;
        dir_row_t   row;
        idle_mode_t mode;
        logic [VAL_W-1:0] mv;
        logic [VAL_W-1:0] pv;
        int cx;
        int cy;
        int cz;

        none         = '0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_MEAS_VAR;
        cfg_data     = '0;
        smp_ch.valid = 1'b0;
        smp_ch.raw_x = '0;
        smp_ch.raw_y = '0;
        smp_ch.raw_z = '0;

        flt_meas_var = MEAS_VAR_RST;
        flt_proc_var = PROC_VAR_RST;
        flt_cov      = '0;
        flt_est_x    = '0;
        flt_est_y    = '0;
        flt_est_z    = '0;

        // Directed table.
        // Reset defaults: first gain is floor(61573 * 2^16 / 2348583) = 1718.
        add_row(0, '0, '0, 0, 0, 0, 1, 0, 0, 0, 1718);
        add_row(0, '0, '0, 32767, -32768, 1, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, -1, 21845, -21846, 0, 0, 0, 0, 0);
        // No measurement noise: gain is one, estimate jumps to the sample.
        add_row(1, '0, PROC_VAR_RST, 32767, -32768, 0, 1, 2147418112, -2147483648, 0, 65536);
        add_row(0, '0, '0, -32768, 32767, -1, 1, -2147483648, 2147418112, -65536, 65536);
        // Zero denominator: both variances and covariance zero, nothing moves.
        add_row(1, '0, '0, 100, 200, 300, 1, -2147483648, 2147418112, -65536, 0);
        add_row(0, '0, '0, -32768, 32767, 0, 1, -2147483648, 2147418112, -65536, 0);
        // Both variances at the top: gain one half, then prior saturation.
        add_row(1, '1, '1, 0, 0, 0, 1, -1073741824, 1073709056, -32768, 32768);
        add_row(0, '0, '0, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, -32768, -32768, -32768, 0, 0, 0, 0, 0);
        // Huge measurement noise, no process noise: gains shrink from sample to sample.
        add_row(1, '1, '0, 12345, -12345, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, -32768, 32767, 21845, 0, 0, 0, 0, 0);
        // Smallest non-zero variances.
        add_row(1, 32'd1, 32'd1, 1, -1, 2, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, -2, 3, -4, 0, 0, 0, 0, 0);
        // Back to defaults, alternating bit patterns and rails.
        add_row(1, MEAS_VAR_RST, PROC_VAR_RST, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, 21845, -21846, 21845, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, -21846, 21845, -21846, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, -32768, -32768, -32768, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, no idling.
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.set_vars) begin
                write_reg(CFG_MEAS_VAR, row.meas);
                write_reg(CFG_PROC_VAR, row.proc);
                write_reg(CFG_SPARE_A, $urandom);
                write_reg(CFG_SPARE_B, $urandom);
            end
            send_sample(row.smp, row.known, row.res);
        end

        // Random phases: new variances each phase, idling schedule rotates.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                mv = MEAS_VAR_RST;
                pv = PROC_VAR_RST;
            end else if (ph == 1) begin
                mv = '1;
                pv = '1;
            end else if (ph == 2) begin
                mv = 32'd1;
                pv = '0;
            end else begin
                mv = pick_var();
                pv = pick_var();
            end
            write_reg(CFG_MEAS_VAR, mv);
            write_reg(CFG_PROC_VAR, pv);
            write_reg(CFG_SPARE_A, $urandom);
            write_reg(CFG_SPARE_B, $urandom);

            // change the idling rates away from the sink's falling-edge update
            @(posedge i_clk);
            mode = idle_mode_t'(ph % 4);
            case (mode)
                IDLE_SEND: begin
                    send_idle_pct  = SEND_IDLE_PCT;
                    recv_stall_pct = 0;
                end
                IDLE_RECV: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = RECV_STALL_PCT;
                end
                IDLE_BOTH: begin
                    send_idle_pct  = BOTH_IDLE_PCT;
                    recv_stall_pct = BOTH_IDLE_PCT;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            cx = int'($urandom_range(65535)) - 32768;
            cy = int'($urandom_range(65535)) - 32768;
            cz = int'($urandom_range(65535)) - 32768;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                s.x = pick_axis(cx);
                s.y = pick_axis(cy);
                s.z = pick_axis(cz);
                send_sample(s, 1'b0, none);
                // long sink hold-off while samples keep coming: block backs up
                if (mode == IDLE_NONE && n == 10)
                    hold_req = 1'b1;
            end
        end

        @(negedge i_clk);
        smp_ch.valid = 1'b0;
        while (est_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && est_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
